>>> rtl/smrd_pkg.sv
// Shared types and constants for the SGR mouse report decoder.
// Has no dependencies. The parser, the click counter and the top level all use it.
package smrd_pkg;

    // Input transaction: a terminal byte or a millisecond tick.
    typedef struct packed {
        logic       operation;
        logic [7:0] byte_value;
    } smrd_in_t;

    // Output transaction: one decoded event.
    typedef struct packed {
        logic [1:0]  event_kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [5:0]  button_code;
        logic        pressed;
        logic [7:0]  click_count;
    } smrd_out_t;

    // Report finished by the parser on the current byte.
    typedef struct packed {
        logic        fire;
        logic [1:0]  kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [5:0]  code;
        logic        down;
    } smrd_rep_t;

    // Operation codes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Event kinds.
    localparam logic [1:0] KIND_BUTTON    = 2'd0;
    localparam logic [1:0] KIND_MOVE      = 2'd1;
    localparam logic [1:0] KIND_FOCUS_IN  = 2'd2;
    localparam logic [1:0] KIND_FOCUS_OUT = 2'd3;

    // Characters of the escape sequences.
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_LT       = 8'h3C;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_PRESS    = 8'h4D;
    localparam logic [7:0] CH_RELEASE  = 8'h6D;
    localparam logic [7:0] CH_FOCUS_IN = 8'h49;
    localparam logic [7:0] CH_FOCUS_OUT = 8'h4F;
    localparam logic [7:0] CH_DIGIT_0  = 8'h30;
    localparam logic [7:0] CH_DIGIT_9  = 8'h39;

    // Click tracking constants.
    localparam logic [7:0]  NO_CODE       = 8'hFF;
    localparam logic [7:0]  CLICK_MAX     = 8'hFF;
    localparam logic [15:0] MS_MAX        = 16'hFFFF;
    localparam logic [15:0] WINDOW_RESET  = 16'd500;
    localparam logic [1:0]  BUTTON_NONE   = 2'd3;

endpackage

>>> rtl/smrd_parser.sv
// Escape sequence parser: tracks the sequence phase and the three decimal fields.
// Depends on smrd_pkg. Produces a finished report for the byte in the input register.
module smrd_parser #(
    parameter int FIELD_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          byte_value,
    output smrd_pkg::smrd_rep_t rep
);
    import smrd_pkg::*;

    localparam int ACC_W = FIELD_BITS + 4;
    localparam int CAP_W = FIELD_BITS + 16;
    localparam logic [FIELD_BITS-1:0] FIELD_MAX = {FIELD_BITS{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ESC,
        PH_CSI,
        PH_FIELDS
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [1:0]            slot_reg, slot_next;
    logic [FIELD_BITS-1:0] field_reg [3];
    logic [FIELD_BITS-1:0] field_next [3];
    logic [FIELD_BITS-1:0] cur_field;
    logic [ACC_W-1:0]      acc;
    logic [ACC_W-1:0]      acc_ext;
    logic [FIELD_BITS-1:0] acc_sat;
    logic                  is_digit;
    logic [5:0]            code;

    // Limit a field to the 16-bit output range.
    function automatic logic [15:0] cap16(input logic [FIELD_BITS-1:0] v);
        logic [CAP_W-1:0] w;
        w = CAP_W'(v);
        return (w > CAP_W'(16'hFFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    // Field currently being read.
    always_comb
    begin
        case (slot_reg)
            2'd0:    cur_field = field_reg[0];
            2'd1:    cur_field = field_reg[1];
            default: cur_field = field_reg[2];
        endcase
    end

    // Decimal accumulate: value * 10 + digit, saturating at the field maximum.
    assign is_digit = (byte_value >= CH_DIGIT_0) && (byte_value <= CH_DIGIT_9);
    assign acc_ext  = ACC_W'(cur_field);
    assign acc      = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(byte_value - CH_DIGIT_0);
    assign acc_sat  = (|acc[ACC_W-1:FIELD_BITS]) ? FIELD_MAX : acc[FIELD_BITS-1:0];

    // Button code from field b: button bits plus shift, meta and ctrl.
    assign code = {field_reg[0][4], field_reg[0][3], field_reg[0][2], 1'b0,
                   field_reg[0][1:0]};

    // Next parse state and the finished report.
    always_comb
    begin
        phase_next    = phase_reg;
        slot_next     = slot_reg;
        field_next[0] = field_reg[0];
        field_next[1] = field_reg[1];
        field_next[2] = field_reg[2];
        rep           = '0;

        if (byte_value == CH_ESC)
        begin
            phase_next = PH_ESC;
            slot_next  = 2'd0;
            field_next[0] = '0;
            field_next[1] = '0;
            field_next[2] = '0;
        end
        else
        begin
            case (phase_reg)
                PH_ESC:
                begin
                    phase_next = (byte_value == CH_LBRACKET) ? PH_CSI : PH_IDLE;
                end
                PH_CSI:
                begin
                    if (byte_value == CH_FOCUS_IN || byte_value == CH_FOCUS_OUT)
                    begin
                        phase_next = PH_IDLE;
                        rep.fire   = 1'b1;
                        rep.kind   = (byte_value == CH_FOCUS_IN) ? KIND_FOCUS_IN
                                                                 : KIND_FOCUS_OUT;
                    end
                    else if (byte_value == CH_LT)
                    begin
                        phase_next = PH_FIELDS;
                        slot_next  = 2'd0;
                        field_next[0] = '0;
                        field_next[1] = '0;
                        field_next[2] = '0;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_FIELDS:
                begin
                    if (byte_value == CH_PRESS || byte_value == CH_RELEASE)
                    begin
                        phase_next = PH_IDLE;
                        slot_next  = 2'd0;
                        field_next[0] = '0;
                        field_next[1] = '0;
                        field_next[2] = '0;
                        rep.fire  = 1'b1;
                        rep.pos_x = cap16(field_reg[1]);
                        rep.pos_y = cap16(field_reg[2]);
                        if (field_reg[0][5])
                        begin
                            rep.kind = KIND_MOVE;
                        end
                        else
                        begin
                            rep.kind = KIND_BUTTON;
                            rep.code = code;
                            rep.down = (byte_value == CH_PRESS);
                        end
                    end
                    else if (byte_value == CH_SEMI)
                    begin
                        if (slot_reg >= 2'd2)
                        begin
                            phase_next = PH_IDLE;
                            slot_next  = 2'd0;
                            field_next[0] = '0;
                            field_next[1] = '0;
                            field_next[2] = '0;
                        end
                        else
                        begin
                            slot_next = slot_reg + 2'd1;
                        end
                    end
                    else if (is_digit)
                    begin
                        case (slot_reg)
                            2'd0:    field_next[0] = acc_sat;
                            2'd1:    field_next[1] = acc_sat;
                            default: field_next[2] = acc_sat;
                        endcase
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        slot_next  = 2'd0;
                        field_next[0] = '0;
                        field_next[1] = '0;
                        field_next[2] = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Parse state registers, updated once per processed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            slot_reg     <= 2'd0;
            field_reg[0] <= '0;
            field_reg[1] <= '0;
            field_reg[2] <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            slot_reg     <= slot_next;
            field_reg[0] <= field_next[0];
            field_reg[1] <= field_next[1];
            field_reg[2] <= field_next[2];
        end
    end

    // The field slot never goes past the third field.
    assert property (@(posedge clk) disable iff (!rst_n) slot_reg != 2'd3)
        else $error("field slot beyond third field");

    // A finished report always returns the parser to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (step && rep.fire) |=> (phase_reg == PH_IDLE))
        else $error("parser not idle after report");

    // Reports come only from the CSI or field phases.
    assert property (@(posedge clk) disable iff (!rst_n)
                     rep.fire |-> (phase_reg == PH_CSI || phase_reg == PH_FIELDS))
        else $error("report from unexpected phase");

endmodule

>>> rtl/smrd_click.sv
// Multi-click tracker: previous code, running click count and time since press.
// Depends on smrd_pkg. Takes the parser's report and millisecond ticks.
module smrd_click (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                tick,
    input  logic [15:0]         window,
    input  smrd_pkg::smrd_rep_t rep,
    output logic [7:0]          click_count
);
    import smrd_pkg::*;

    logic [7:0]  prev_code_reg, prev_code_next;
    logic [7:0]  clicks_reg, clicks_next;
    logic [15:0] ms_reg, ms_next;
    logic        press;
    logic        repeat_press;

    assign press        = advance && rep.fire && (rep.kind == KIND_BUTTON) && rep.down;
    assign repeat_press = (prev_code_reg == {2'b00, rep.code}) && (ms_reg <= window);

    // Click state update for presses and ticks.
    always_comb
    begin
        prev_code_next = prev_code_reg;
        clicks_next    = clicks_reg;
        ms_next        = ms_reg;
        if (advance && tick)
        begin
            if (ms_reg != MS_MAX)
            begin
                ms_next = ms_reg + 16'd1;
            end
        end
        else if (press)
        begin
            if (repeat_press)
            begin
                if (clicks_reg != CLICK_MAX)
                begin
                    clicks_next = clicks_reg + 8'd1;
                end
            end
            else
            begin
                prev_code_next = (rep.code[1:0] != BUTTON_NONE) ? {2'b00, rep.code}
                                                                 : NO_CODE;
                clicks_next    = 8'd1;
            end
            ms_next = 16'd0;
        end
    end

    // Count shown with a button event: running count on press, one on release.
    assign click_count = rep.down ? clicks_next : 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_code_reg <= NO_CODE;
            clicks_reg    <= 8'd0;
            ms_reg        <= 16'd0;
        end
        else
        begin
            prev_code_reg <= prev_code_next;
            clicks_reg    <= clicks_next;
            ms_reg        <= ms_next;
        end
    end

    // A press restarts the timer and leaves a nonzero count.
    assert property (@(posedge clk) disable iff (!rst_n)
                     press |=> (ms_reg == 16'd0 && clicks_reg != 8'd0))
        else $error("press did not restart click state");

    // A press of button bits 3 never leaves a code to repeat.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (press && rep.code[1:0] == BUTTON_NONE) |=> (prev_code_reg == NO_CODE))
        else $error("button 3 press recorded a code");

    // The millisecond timer saturates instead of wrapping.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (advance && tick && ms_reg == MS_MAX) |=> (ms_reg == MS_MAX))
        else $error("millisecond timer wrapped");

endmodule

>>> rtl/sgr_mouse_report_decoder_core.sv
// Decodes a terminal byte stream into SGR mouse button, move and focus events, and
// times multi-clicks from millisecond tick transactions. The double-click window is
// the one configuration register (500 ms after reset); write it only while no
// transaction is in flight. Throughput is one transaction per clock when the output
// register has space. A byte or tick is captured in the input register and passes
// the parser and click tracker once the output register has space; the result is
// then loaded into the output register, where it waits until taken. The input side
// keeps taking transactions while a result waits, until the input register is also
// full. Depends on smrd_pkg, smrd_parser and smrd_click.
module sgr_mouse_report_decoder_core #(
    parameter int FIELD_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  smrd_pkg::smrd_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output smrd_pkg::smrd_out_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);
    import smrd_pkg::*;

    logic      in_valid_reg, in_valid_next;
    smrd_in_t  in_data_reg;
    logic      out_valid_reg, out_valid_next;
    smrd_out_t out_data_reg, out_data_next;
    logic [15:0] window_reg;
    logic      space;
    logic      advance;
    logic      is_tick;
    smrd_rep_t rep;
    logic [7:0] clicks;

    // Pipeline control: the input register drains when the output can take it.
    assign space    = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && space;
    assign in_ready = !in_valid_reg || space;
    assign is_tick  = (in_data_reg.operation == OP_TICK);
    assign cfg_ready = 1'b1;

    smrd_parser #(
        .FIELD_BITS (FIELD_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance && !is_tick),
        .byte_value (in_data_reg.byte_value),
        .rep        (rep)
    );

    smrd_click u_click (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .tick        (is_tick),
        .window      (window_reg),
        .rep         (rep),
        .click_count (clicks)
    );

    // Next input and output register values.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance)
        begin
            out_valid_next = rep.fire && !is_tick;
            out_data_next.event_kind  = rep.kind;
            out_data_next.pos_x       = rep.pos_x;
            out_data_next.pos_y       = rep.pos_y;
            out_data_next.button_code = rep.code;
            out_data_next.pressed     = rep.down;
            out_data_next.click_count = (rep.kind == KIND_BUTTON) ? clicks : 8'd0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            window_reg    <= WINDOW_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                window_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> test/smrd_checker.sv
// Checker for the SGR mouse report decoder: tracks the parser and click state,
// predicts each decoded event and compares it with what the block produces.
// Depends on smrd_pkg for the transaction types and character codes.
module smrd_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  smrd_pkg::smrd_in_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  smrd_pkg::smrd_out_t out_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    output int                  pending,
    output int                  errors
);
    import smrd_pkg::*;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_ESC,
        SCAN_CSI,
        SCAN_FIELDS
    } scan_phase_t;

    localparam logic [19:0] FIELD_CAP = 20'h0FFFF;

    // Shadow copy of the decoder state.
    scan_phase_t scan_phase;
    logic [1:0]  field_idx;
    logic [15:0] field_val [3];
    logic [7:0]  last_code;
    logic [7:0]  click_run;
    logic [15:0] ms_idle;
    logic [15:0] click_window;

    smrd_out_t   expected_events [$];
    int          mismatches;

    function automatic void clear_fields();
        field_idx    = '0;
        field_val[0] = '0;
        field_val[1] = '0;
        field_val[2] = '0;
    endfunction

    // Advance the shadow state by one input transaction. Returns 1 when the
    // transaction completes an event, which is then left in ev.
    function automatic bit decode_transaction(input smrd_in_t it, output smrd_out_t ev);
        logic [7:0]  ch;
        logic [19:0] acc;
        logic [15:0] b;
        logic [5:0]  code;
        ev = '0;
        decode_transaction = 1'b0;
        if (it.operation == OP_TICK)
        begin
            if (ms_idle != MS_MAX)
                ms_idle = ms_idle + 16'd1;
            return 1'b0;
        end
        ch = it.byte_value;
        // ESC restarts a sequence from any phase.
        if (ch == CH_ESC)
        begin
            scan_phase = SCAN_ESC;
            clear_fields();
            return 1'b0;
        end
        case (scan_phase)
            SCAN_ESC:
                scan_phase = (ch == CH_LBRACKET) ? SCAN_CSI : SCAN_IDLE;
            SCAN_CSI:
                if (ch == CH_FOCUS_IN || ch == CH_FOCUS_OUT)
                begin
                    scan_phase = SCAN_IDLE;
                    ev.event_kind = (ch == CH_FOCUS_IN) ? KIND_FOCUS_IN : KIND_FOCUS_OUT;
                    decode_transaction = 1'b1;
                end
                else if (ch == CH_LT)
                begin
                    scan_phase = SCAN_FIELDS;
                    clear_fields();
                end
                else
                begin
                    scan_phase = SCAN_IDLE;
                end
            SCAN_FIELDS:
                if (ch == CH_PRESS || ch == CH_RELEASE)
                begin
                    b = field_val[0];
                    ev.pos_x = field_val[1];
                    ev.pos_y = field_val[2];
                    scan_phase = SCAN_IDLE;
                    clear_fields();
                    decode_transaction = 1'b1;
                    if (b[5])
                    begin
                        // Move reports carry only the coordinates.
                        ev.event_kind = KIND_MOVE;
                    end
                    else
                    begin
                        code = {b[4:2], 1'b0, b[1:0]};
                        ev.event_kind  = KIND_BUTTON;
                        ev.button_code = code;
                        ev.pressed     = (ch == CH_PRESS);
                        ev.click_count = 8'd1;
                        if (ch == CH_PRESS)
                        begin
                            // Same code again inside the window counts as a multi-click.
                            if (last_code == {2'b00, code} && ms_idle <= click_window)
                            begin
                                if (click_run != CLICK_MAX)
                                    click_run = click_run + 8'd1;
                            end
                            else
                            begin
                                last_code = (code[1:0] == BUTTON_NONE) ? NO_CODE
                                                                       : {2'b00, code};
                                click_run = 8'd1;
                            end
                            ms_idle = '0;
                            ev.click_count = click_run;
                        end
                    end
                end
                else if (ch == CH_SEMI)
                begin
                    // A fourth field drops the whole sequence.
                    if (field_idx >= 2'd2)
                    begin
                        scan_phase = SCAN_IDLE;
                        clear_fields();
                    end
                    else
                    begin
                        field_idx = field_idx + 2'd1;
                    end
                end
                else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9)
                begin
                    acc = 20'(field_val[field_idx]) * 20'd10 + 20'(ch - CH_DIGIT_0);
                    field_val[field_idx] = (acc > FIELD_CAP) ? 16'hFFFF : acc[15:0];
                end
                else
                begin
                    scan_phase = SCAN_IDLE;
                    clear_fields();
                end
            default:
                scan_phase = SCAN_IDLE;
        endcase
    endfunction

    // Watch all three channels; results are checked before the new input is
    // predicted, since an input cannot produce its event on the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        smrd_out_t want;
        smrd_out_t ev;
        if (!rst_n)
        begin
            scan_phase   = SCAN_IDLE;
            clear_fields();
            last_code    = NO_CODE;
            click_run    = '0;
            ms_idle      = '0;
            click_window = WINDOW_RESET;
            mismatches   = 0;
            expected_events.delete();
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                click_window = cfg_data;

            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    if (mismatches < 10)
                        $display({"unexpected event: kind=%0d x=%0d y=%0d code=%0d",
                                  " down=%0d clicks=%0d"},
                                 out_data.event_kind, out_data.pos_x, out_data.pos_y,
                                 out_data.button_code, out_data.pressed,
                                 out_data.click_count);
                    mismatches++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (out_data.event_kind !== want.event_kind ||
                        out_data.pos_x !== want.pos_x ||
                        out_data.pos_y !== want.pos_y ||
                        out_data.button_code !== want.button_code ||
                        out_data.pressed !== want.pressed ||
                        out_data.click_count !== want.click_count)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("event mismatch at %0t", $realtime);
                            $display({"  expected kind=%0d x=%0d y=%0d code=%0d",
                                      " down=%0d clicks=%0d"},
                                     want.event_kind, want.pos_x, want.pos_y,
                                     want.button_code, want.pressed, want.click_count);
                            $display({"  actual   kind=%0d x=%0d y=%0d code=%0d",
                                      " down=%0d clicks=%0d"},
                                     out_data.event_kind, out_data.pos_x, out_data.pos_y,
                                     out_data.button_code, out_data.pressed,
                                     out_data.click_count);
                        end
                        mismatches++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                if (decode_transaction(in_data, ev))
                    expected_events.insert(expected_events.size(), ev);
            end

            pending <= expected_events.size();
            errors  <= mismatches;
        end
    end

endmodule

>>> test/tb_top.sv
// Top of the SGR mouse report decoder testbench: clock, reset, byte and tick
// stimulus, output back-pressure and the final verdict.
// Depends on smrd_pkg, sgr_mouse_report_decoder_core and smrd_checker.
module tb_top;
    import smrd_pkg::*;

    localparam int HOLD_CYCLES = 48;
    localparam int QUIET_LIMIT = 1000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    smrd_in_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    smrd_out_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    int pending;
    int errors;
    int sent_items = 0;
    int quiet      = 0;
    int last_b     = 0;
    bit tx_idle    = 1'b1;
    bit rx_idle    = 1'b1;
    bit hold_req   = 1'b0;

    always #2 clk = ~clk;

    sgr_mouse_report_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    smrd_checker u_event_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    // End the run when no transaction of any kind moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Output side: random stall bursts, plus one long hold on request.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_idle && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offer one input transaction and hold it until accepted.
    task automatic put_item(input smrd_in_t it);
        in_data  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sent_items++;
        if (tx_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        smrd_in_t it;
        it.operation  = OP_BYTE;
        it.byte_value = b;
        put_item(it);
    endtask

    // Ticks carry a random byte, which the block must ignore.
    task automatic send_tick();
        smrd_in_t it;
        it.operation  = OP_TICK;
        it.byte_value = 8'($urandom_range(0, 255));
        put_item(it);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_seq(input string body);
        send_byte(CH_ESC);
        send_text(body);
    endtask

    // Wait until every expected event has come out, then a few cycles more.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_window(input logic [15:0] w);
        cfg_data  <= w;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Decimal text for a coordinate: mostly small, sometimes empty or past the cap.
    function automatic string coord_text();
        int    r;
        string s;
        r = $urandom_range(0, 19);
        s = "";
        case (r)
            0: s = "";
            1: s = "65535";
            2: s = "65536";
            3:
            begin
                repeat ($urandom_range(6, 9))
                    s = {s, $sformatf("%0d", $urandom_range(0, 9))};
            end
            4: s = $sformatf("0%0d", $urandom_range(0, 99));
            default: s = $sformatf("%0d", $urandom_range(0, 400));
        endcase
        return s;
    endfunction

    // A well-formed mouse report body; presses often repeat the previous button.
    function automatic string report_text();
        int    b;
        int    r;
        int    nf;
        bit    down;
        string term;
        string bs;
        r = $urandom_range(0, 19);
        if (r < 8)
            b = last_b;
        else if (r < 14)
            b = $urandom_range(0, 31);
        else if (r < 17)
            b = $urandom_range(32, 63);
        else if (r < 19)
            b = $urandom_range(64, 1000);
        else
            b = 70000;
        down = ($urandom_range(0, 9) < 7);
        term = down ? "M" : "m";
        if (down)
            last_b = b;
        bs = $sformatf("%0d", b);
        nf = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : 3;
        case (nf)
            0: return {"[<", term};
            1: return {"[<", bs, term};
            2: return {"[<", bs, ";", coord_text(), term};
            default: return {"[<", bs, ";", coord_text(), ";", coord_text(), term};
        endcase
    endfunction

    // Mostly well-formed reports, focus changes and ticks, with broken
    // sequences and stray bytes mixed in, until target transactions are sent.
    task automatic run_random(input int target, input int tick_span, input bit calm);
        int    start;
        int    pick;
        int    k;
        string body;
        start = sent_items;
        while (sent_items - start < target)
        begin
            if (calm)
            begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 24) == 0)
                    tx_idle = !tx_idle;
                if ($urandom_range(0, 24) == 0)
                    rx_idle = !rx_idle;
            end
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                send_seq(report_text());
            end
            else if (pick < 60)
            begin
                send_seq($urandom_range(0, 1) ? "[I" : "[O");
            end
            else if (pick < 72)
            begin
                repeat ($urandom_range(1, tick_span + 1)) send_tick();
            end
            else if (pick < 82)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        // Fourth field drops the sequence; the tail is then ignored.
                        send_seq({"[<", $sformatf("%0d", $urandom_range(0, 31)), ";",
                                  coord_text(), ";", coord_text(), ";",
                                  coord_text(), "M"});
                    end
                    1:
                    begin
                        // Sequence cut short by an arbitrary byte.
                        body = report_text();
                        k = $urandom_range(1, body.len() - 1);
                        send_seq(body.substr(0, k - 1));
                        send_byte(8'($urandom_range(0, 255)));
                    end
                    2:
                    begin
                        // Sequence restarted by ESC in the middle.
                        body = report_text();
                        k = $urandom_range(1, body.len() - 1);
                        send_seq(body.substr(0, k - 1));
                        send_seq(report_text());
                    end
                    default:
                    begin
                        send_seq("[");
                        send_byte(8'($urandom_range(0, 255)));
                    end
                endcase
            end
            else if (pick < 92)
            begin
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                send_byte(CH_ESC);
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        logic [15:0] w;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Focus in and out, a press with a capped column and missing row,
        // a move closed by a release, a tick and a stray byte.
        send_seq("[I");
        send_seq("[O");
        send_seq("[<1;99999M");
        send_seq("[<32m");
        send_tick();
        send_text("x");

        // Long output hold while focus reports keep coming, so the input stalls.
        tx_idle  = 1'b0;
        hold_req = 1'b1;
        repeat (20) send_seq($urandom_range(0, 1) ? "[I" : "[O");
        tx_idle = 1'b1;

        // Random traffic with the window left at its reset value.
        run_random(150, 20, 1'b0);

        // Zero window: back-to-back presses drive the click count to its cap.
        drain();
        write_window(16'd0);
        repeat (256) send_seq("[<M");

        // Small random window: a repeat press exactly at the window, then one
        // tick past it, and ticks spread around it.
        drain();
        w = 16'($urandom_range(1, 10));
        write_window(w);
        send_seq("[<2;5;5M");
        repeat (w) send_tick();
        send_seq("[<2;5;5M");
        repeat (int'(w) + 1) send_tick();
        send_seq("[<2;5;5M");
        run_random(130, int'(w) + 3, 1'b0);

        // Last stretch with no idling on either side.
        drain();
        w = 16'($urandom_range(1, 6));
        write_window(w);
        run_random(130, int'(w) + 3, 1'b1);

        drain();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
